@@ src/sm32_pkg.sv @@
// ----------------------------------------------------------------------------
// sm32_pkg
// Shared types and constants for the 32-bit stack machine integer ALU.
// ----------------------------------------------------------------------------
package sm32_pkg;

  localparam int WORD_W          = 32;
  localparam int OP_W            = 5;
  localparam int TRAP_W          = 2;
  localparam int SHAMT_W         = 5;
  localparam int DIV_BITS_PER_ST = 4;
  localparam int DIV_STAGES      = WORD_W / DIV_BITS_PER_ST;

  localparam logic [WORD_W-1:0] WORD_MIN     = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] WORD_ALLONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] WORD_ONE     = {{(WORD_W-1){1'b0}}, 1'b1};
  localparam logic [WORD_W-1:0] WORD_ZERO    = {WORD_W{1'b0}};

  typedef enum logic [OP_W-1:0] {
    OP_EQ  = 5'd0,
    OP_NE  = 5'd1,
    OP_LT  = 5'd2,
    OP_GT  = 5'd3,
    OP_LE  = 5'd4,
    OP_GE  = 5'd5,
    OP_ADD = 5'd6,
    OP_SUB = 5'd7,
    OP_MUL = 5'd8,
    OP_DIV = 5'd9,
    OP_REM = 5'd10,
    OP_AND = 5'd11,
    OP_OR  = 5'd12,
    OP_XOR = 5'd13,
    OP_SHL = 5'd14,
    OP_SHR = 5'd15,
    OP_EQZ = 5'd16
  } op_t;

  typedef enum logic [TRAP_W-1:0] {
    TRAP_NONE     = 2'd0,
    TRAP_DIV_ZERO = 2'd1,
    TRAP_OVERFLOW = 2'd2
  } trap_t;

  // Information that rides alongside an operation through the divider.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] res;
    trap_t             trap;
    logic              neg_q;
    logic              neg_r;
  } side_t;

endpackage

@@ src/sm32_div.sv @@
// ----------------------------------------------------------------------------
// sm32_div
// Pipelined unsigned restoring divider, several quotient bits per stage.
// ----------------------------------------------------------------------------
module sm32_div
  import sm32_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [WORD_W-1:0] in_dvd,
  input  logic [WORD_W-1:0] in_dvs,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_quo,
  output logic [WORD_W-1:0] out_rem,
  output side_t             out_side
);

  logic              v_r    [DIV_STAGES];
  logic [WORD_W-1:0] q_r    [DIV_STAGES];
  logic [WORD_W-1:0] rm_r   [DIV_STAGES];
  logic [WORD_W-1:0] d_r    [DIV_STAGES];
  side_t             side_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
    logic              v_in;
    logic [WORD_W-1:0] q_in, rm_in, d_in;
    side_t             side_in;
    logic [WORD_W-1:0] q_nxt, rm_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign q_in    = in_dvd;
      assign rm_in   = WORD_ZERO;
      assign d_in    = in_dvs;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[k-1];
      assign q_in    = q_r[k-1];
      assign rm_in   = rm_r[k-1];
      assign d_in    = d_r[k-1];
      assign side_in = side_r[k-1];
    end

    // The dividend shifts out of the top of q while quotient bits enter below.
    always_comb begin
      logic [WORD_W:0]   t;
      logic [WORD_W-1:0] q, rm;
      q  = q_in;
      rm = rm_in;
      for (int i = 0; i < DIV_BITS_PER_ST; i++) begin
        t = {rm, q[WORD_W-1]};
        q = {q[WORD_W-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t    = t - {1'b0, d_in};
          q[0] = 1'b1;
        end
        rm = t[WORD_W-1:0];
      end
      q_nxt  = q;
      rm_nxt = rm;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= q_nxt;
        rm_r[k]   <= rm_nxt;
        d_r[k]    <= d_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quo   = q_r[DIV_STAGES-1];
  assign out_rem   = rm_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

@@ src/stack_machine_i32_alu.sv @@
// ----------------------------------------------------------------------------
// stack_machine_i32_alu
// Executes one 32-bit integer instruction of a stack virtual machine and
// returns its result together with a trap code.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------
//  in_     | input     | in_valid / in_stall | in_req_type, in_lhs, in_rhs
//  out_    | output    | out_valid/out_stall | out_value_out, out_trap_code
//
// A transaction enters every cycle in which in_stall is low. Every transaction
// passes through the divider, which retires four quotient
// bits per stage over eight stages, framed by an input register, an operand
// stage (which also holds the single multiplier) and the output register.
// Reset clears every valid bit; payload registers are not reset.
// When a result waits at the output and is stalled, the whole pipeline holds
// and in_stall is raised, so nothing is lost or repeated.
//
module stack_machine_i32_alu
  import sm32_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_req_type,
  input  logic signed [WORD_W-1:0] in_lhs,
  input  logic signed [WORD_W-1:0] in_rhs,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_value_out,
  output logic [TRAP_W-1:0]        out_trap_code
);

  // The pipeline moves as one whenever the output register can advance.
  logic out_valid_r;
  logic adv;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 0: input register.
  logic              v0_r;
  op_t               op0_r;
  logic [WORD_W-1:0] a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r <= op_t'(in_req_type);
      a0_r  <= in_lhs;
      b0_r  <= in_rhs;
    end
  end

  // Stage 1: every operation except divide and remainder completes here,
  // and the divider operands are reduced to magnitudes with their signs noted.
  side_t             side1_nxt, side1_r;
  logic [WORD_W-1:0] dvd1_nxt, dvs1_nxt, dvd1_r, dvs1_r;
  logic              v1_r;

  always_comb begin
    logic [WORD_W-1:0] res;
    trap_t             trap;
    logic              sa, sb;
    res  = WORD_ZERO;
    trap = TRAP_NONE;
    sa   = a0_r[WORD_W-1];
    sb   = b0_r[WORD_W-1];
    case (op0_r)
      OP_EQ:  res = (a0_r == b0_r) ? WORD_ONE : WORD_ZERO;
      OP_NE:  res = (a0_r != b0_r) ? WORD_ONE : WORD_ZERO;
      OP_LT:  res = ($signed(a0_r) <  $signed(b0_r)) ? WORD_ONE : WORD_ZERO;
      OP_GT:  res = ($signed(a0_r) >  $signed(b0_r)) ? WORD_ONE : WORD_ZERO;
      OP_LE:  res = ($signed(a0_r) <= $signed(b0_r)) ? WORD_ONE : WORD_ZERO;
      OP_GE:  res = ($signed(a0_r) >= $signed(b0_r)) ? WORD_ONE : WORD_ZERO;
      OP_ADD: res = a0_r + b0_r;
      OP_SUB: res = a0_r - b0_r;
      OP_MUL: res = a0_r * b0_r;
      OP_DIV: begin
        if (b0_r == WORD_ZERO) begin
          trap = TRAP_DIV_ZERO;
        end else if (a0_r == WORD_MIN && b0_r == WORD_ALLONES) begin
          trap = TRAP_OVERFLOW;
        end
      end
      OP_REM: begin
        if (b0_r == WORD_ZERO) begin
          trap = TRAP_DIV_ZERO;
        end
      end
      OP_AND: res = a0_r & b0_r;
      OP_OR:  res = a0_r | b0_r;
      OP_XOR: res = a0_r ^ b0_r;
      OP_SHL: res = a0_r << b0_r[SHAMT_W-1:0];
      OP_SHR: res = WORD_W'($signed(a0_r) >>> b0_r[SHAMT_W-1:0]);
      OP_EQZ: res = (a0_r == WORD_ZERO) ? WORD_ONE : WORD_ZERO;
      default: res = WORD_ZERO;
    endcase
    side1_nxt.op    = op0_r;
    side1_nxt.res   = res;
    side1_nxt.trap  = trap;
    side1_nxt.neg_q = sa ^ sb;
    side1_nxt.neg_r = sa;
    dvd1_nxt = sa ? (WORD_ZERO - a0_r) : a0_r;
    dvs1_nxt = sb ? (WORD_ZERO - b0_r) : b0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r <= side1_nxt;
      dvd1_r  <= dvd1_nxt;
      dvs1_r  <= dvs1_nxt;
    end
  end

  // Stages 2 to 9: the divider, with the other results riding alongside.
  logic              vd;
  logic [WORD_W-1:0] quo, rem;
  side_t             sided;

  sm32_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v1_r),
    .in_dvd    (dvd1_r),
    .in_dvs    (dvs1_r),
    .in_side   (side1_r),
    .out_valid (vd),
    .out_quo   (quo),
    .out_rem   (rem),
    .out_side  (sided)
  );

  // Output register: signs are restored and a trap forces the value to zero.
  logic [WORD_W-1:0] val_nxt, val_r;
  trap_t             trap_r;

  always_comb begin
    if (sided.trap != TRAP_NONE) begin
      val_nxt = WORD_ZERO;
    end else if (sided.op == OP_DIV) begin
      val_nxt = sided.neg_q ? (WORD_ZERO - quo) : quo;
    end else if (sided.op == OP_REM) begin
      val_nxt = sided.neg_r ? (WORD_ZERO - rem) : rem;
    end else begin
      val_nxt = sided.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r  <= val_nxt;
      trap_r <= sided.trap;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = val_r;
  assign out_trap_code = trap_r;

endmodule
